// ----- rtl/pgfe_pkg.sv -----
`default_nettype none
package pgfe_pkg;

	localparam int COORD_W    = 12;
	localparam int MAG_W      = 11;
	localparam int GREY_W     = 4;
	localparam int COLOUR_W   = 16;
	localparam int PAL_W      = 64;
	localparam int PAL_REGS   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int BYTE_W     = 2 * GREY_W;
	localparam int PIX_FULL_W = 2 * MAG_W;

	typedef enum logic [1:0] {
		FUNC_PLOT = 2'd0,
		FUNC_MAX  = 2'd1,
		FUNC_FILL = 2'd2,
		FUNC_READ = 2'd3
	} func_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pgfe_ram.sv -----
`default_nettype none
module pgfe_ram
	import pgfe_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 27200
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [addr_bits(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]            wdata,
	input  wire logic                        re,
	input  wire logic [addr_bits(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/packed_grey_framebuffer_engine.sv -----
`default_nettype none
// Plot, max-plot and read requests: once accepted, a request passes through S_RD, which
// forms the address and reads the memory, then S_WB, which modifies, writes back and loads
// the output registers; S_WB waits while the output is stalled. A new request is taken in
// S_IDLE, or in S_WB as the result is loaded; an off-screen request goes via S_EMIT to S_IDLE.
// Fill: one byte per cycle over all PANEL_WIDTH*PANEL_HEIGHT/2 rounded up bytes, then S_EMIT.
// Reset: a clearing pass writes black to all PANEL_WIDTH*PANEL_HEIGHT/2 rounded up bytes;
// no request is taken meanwhile, configuration writes are. Palette resets to zero.
module packed_grey_framebuffer_engine
	import pgfe_pkg::*;
#(
	parameter int PANEL_WIDTH  = 320,
	parameter int PANEL_HEIGHT = 170
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 func,
	input  wire logic signed [COORD_W-1:0]  x_coord,
	input  wire logic signed [COORD_W-1:0]  y_coord,
	input  wire logic [GREY_W-1:0]          grey_level,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [COLOUR_W-1:0]             left_colour,
	output logic [COLOUR_W-1:0]             right_colour,
	output logic                            accepted,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [PAL_W-1:0]           cfg_data
);

	localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 1) / 2;
	localparam int ADDR_W      = addr_bits(STORE_BYTES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_WB,
		S_SWEEP,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic [PAL_W-1:0]        pal_q [PAL_REGS];
	logic [ADDR_W-1:0]       fill_q;
	logic                    rpt_q;
	logic [GREY_W-1:0]       fill_lvl_q;

	func_t                   func_s1;
	logic [COORD_W-1:0]      x_s1;
	logic [COORD_W-1:0]      y_s1;
	logic [GREY_W-1:0]       grey_s1;
	logic [ADDR_W-1:0]       idx_s2;
	logic                    low_s2;

	logic                    out_valid_q;
	logic [COLOUR_W-1:0]     left_q;
	logic [COLOUR_W-1:0]     right_q;
	logic                    acc_q;

	logic                    can_emit;
	logic                    emit_now;
	logic                    on_screen;
	logic [PIX_FULL_W-1:0]   pix;
	logic [ADDR_W-1:0]       rd_idx;
	logic [BYTE_W-1:0]       cur;
	logic [GREY_W-1:0]       old_lvl;
	logic                    do_write;
	logic [BYTE_W-1:0]       new_byte;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [BYTE_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [BYTE_W-1:0]       ram_rdata;
	logic                    sweep_last;

	function automatic logic [COLOUR_W-1:0] colour_of(input logic [PAL_W-1:0] word,
			input logic [1:0] slot);
		return word[slot * COLOUR_W +: COLOUR_W];
	endfunction

	assign can_emit   = !out_valid_q || out_ready;
	assign emit_now   = ((state_q == S_WB) || (state_q == S_EMIT)) && can_emit;
	assign in_ready   = (state_q == S_IDLE) || ((state_q == S_WB) && can_emit);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign left_colour  = left_q;
	assign right_colour = right_q;
	assign accepted     = acc_q;

	assign on_screen = !x_s1[COORD_W-1] && !y_s1[COORD_W-1]
		&& ({1'b0, x_s1[MAG_W-1:0]} < COORD_W'(PANEL_WIDTH))
		&& ({1'b0, y_s1[MAG_W-1:0]} < COORD_W'(PANEL_HEIGHT));
	assign pix = PIX_FULL_W'(y_s1[MAG_W-1:0]) * PIX_FULL_W'(PANEL_WIDTH)
		+ PIX_FULL_W'(x_s1[MAG_W-1:0]);
	assign rd_idx = ADDR_W'(pix >> 1);

	assign cur      = ram_rdata;
	assign old_lvl  = low_s2 ? cur[GREY_W-1:0] : cur[BYTE_W-1:GREY_W];
	assign do_write = (func_s1 == FUNC_PLOT) || ((func_s1 == FUNC_MAX) && (grey_s1 > old_lvl));
	assign new_byte = low_s2 ? {cur[BYTE_W-1:GREY_W], grey_s1} : {grey_s1, cur[GREY_W-1:0]};

	assign sweep_last = (fill_q == ADDR_W'(STORE_BYTES - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s2;
		ram_wdata = new_byte;
		if (state_q == S_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q;
			ram_wdata = {fill_lvl_q, fill_lvl_q};
		end else if ((state_q == S_WB) && can_emit && do_write) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == S_RD) && on_screen && (func_s1 != FUNC_FILL);

	pgfe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAL_REGS; i++) begin
				pal_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			pal_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			fill_q      <= '0;
			rpt_q       <= 1'b0;
			fill_lvl_q  <= '0;
			out_valid_q <= 1'b0;
			acc_q       <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			func_s1     <= FUNC_PLOT;
			x_s1        <= '0;
			y_s1        <= '0;
			grey_s1     <= '0;
			idx_s2      <= '0;
			low_s2      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit_now) begin
				out_valid_q <= 1'b0;
			end
			if (in_valid && in_ready) begin
				func_s1 <= func_t'(func);
				x_s1    <= x_coord;
				y_s1    <= y_coord;
				grey_s1 <= grey_level;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					idx_s2 <= rd_idx;
					low_s2 <= pix[0];
					if (func_s1 == FUNC_FILL) begin
						fill_q     <= '0;
						fill_lvl_q <= grey_s1;
						rpt_q      <= 1'b1;
						state_q    <= S_SWEEP;
					end else if (on_screen) begin
						state_q <= S_WB;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_WB: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						acc_q       <= 1'b1;
						if (func_s1 == FUNC_READ) begin
							left_q  <= colour_of(pal_q[cur[BYTE_W-1:BYTE_W-2]],
								cur[BYTE_W-3:GREY_W]);
							right_q <= colour_of(pal_q[cur[GREY_W-1:GREY_W-2]],
								cur[GREY_W-3:0]);
						end else begin
							left_q  <= '0;
							right_q <= '0;
						end
						state_q <= in_valid ? S_RD : S_IDLE;
					end
				end
				S_SWEEP: begin
					if (sweep_last) begin
						fill_q  <= '0;
						state_q <= rpt_q ? S_EMIT : S_IDLE;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						acc_q       <= rpt_q;
						left_q      <= '0;
						right_q     <= '0;
						rpt_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- bench/packed_grey_framebuffer_engine_test.sv -----
`timescale 1ns / 1ps
module packed_grey_framebuffer_engine_test;
	import pgfe_pkg::*;

	localparam int PANEL_W     = 320;
	localparam int PANEL_H     = 170;
	localparam int STORE_BYTES = (PANEL_W * PANEL_H + 1) / 2;

	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_0_3   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_4_7   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_8_11  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_12_15 = 2'd3;

	typedef struct packed {
		logic [COLOUR_W-1:0] left_c;
		logic [COLOUR_W-1:0] right_c;
		logic                acc;
	} pair_result_t;

	class grey_frame_scoreboard;
		logic [BYTE_W-1:0] pixel_bytes[];
		logic [PAL_W-1:0]  palette[PAL_REGS];
		pair_result_t      expected_pairs[$];
		int mismatches;
		int requests;
		int fills;
		int reads;
		int offscreen;

		function new();
			pixel_bytes = new[STORE_BYTES];
			foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
			foreach (palette[i]) palette[i] = '0;
			mismatches = 0;
			requests = 0;
			fills = 0;
			reads = 0;
			offscreen = 0;
		endfunction

		function void set_palette_reg(logic [CFG_IDX_W-1:0] idx, logic [PAL_W-1:0] data);
			palette[idx] = data;
		endfunction

		function logic [COLOUR_W-1:0] colour_for(logic [GREY_W-1:0] lvl);
			return palette[lvl[3:2]][lvl[1:0]*COLOUR_W +: COLOUR_W];
		endfunction

		function int pending();
			return expected_pairs.size();
		endfunction

		function void note_request(func_t f, logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] y, logic [GREY_W-1:0] lvl);
			pair_result_t res;
			int xi;
			int yi;
			int pix;
			int idx;
			logic [BYTE_W-1:0] cur;
			logic [GREY_W-1:0] old;
			xi = x;
			yi = y;
			res = '0;
			requests++;
			if (f == FUNC_FILL) begin
				fills++;
				foreach (pixel_bytes[i]) pixel_bytes[i] = {lvl, lvl};
				res.acc = 1'b1;
			end else if (xi >= 0 && xi < PANEL_W && yi >= 0 && yi < PANEL_H) begin
				pix = yi * PANEL_W + xi;
				idx = pix >> 1;
				cur = pixel_bytes[idx];
				old = pix[0] ? cur[3:0] : cur[7:4];
				res.acc = 1'b1;
				if (f == FUNC_READ) begin
					reads++;
					res.left_c  = colour_for(cur[7:4]);
					res.right_c = colour_for(cur[3:0]);
				end else if (f == FUNC_PLOT || lvl > old) begin
					if (pix[0])
						pixel_bytes[idx] = {cur[7:4], lvl};
					else
						pixel_bytes[idx] = {lvl, cur[3:0]};
				end
			end else begin
				offscreen++;
			end
			expected_pairs.push_back(res);
		endfunction

		function void check_colours(logic [COLOUR_W-1:0] l, logic [COLOUR_W-1:0] r, logic a);
			pair_result_t want;
			if (expected_pairs.size() == 0) begin
				$display("%0t: result with nothing expected: left %h right %h accepted %b",
					$time, l, r, a);
				mismatches++;
				return;
			end
			want = expected_pairs.pop_front();
			if (l !== want.left_c) begin
				$display("%0t: left_colour expected %h actual %h", $time, want.left_c, l);
				mismatches++;
			end
			if (r !== want.right_c) begin
				$display("%0t: right_colour expected %h actual %h", $time, want.right_c, r);
				mismatches++;
			end
			if (a !== want.acc) begin
				$display("%0t: accepted expected %b actual %b", $time, want.acc, a);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FUNC_PLOT;
	logic signed [COORD_W-1:0] x_coord = '0;
	logic signed [COORD_W-1:0] y_coord = '0;
	logic [GREY_W-1:0] grey_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [COLOUR_W-1:0] left_colour;
	logic [COLOUR_W-1:0] right_colour;
	logic accepted;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PAL_W-1:0] cfg_data = '0;

	grey_frame_scoreboard sb = new();
	int results_seen = 0;
	int palette_settings = 0;
	int random_fills = 0;

	packed_grey_framebuffer_engine #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.grey_level  (grey_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_colour (left_colour),
		.right_colour(right_colour),
		.accepted    (accepted),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic write_cfg_reg(logic [CFG_IDX_W-1:0] idx, logic [PAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_palette_reg(idx, data);
	endtask

	task automatic set_palette(logic [PAL_W-1:0] p0, logic [PAL_W-1:0] p1,
			logic [PAL_W-1:0] p2, logic [PAL_W-1:0] p3);
		write_cfg_reg(REG_LEVELS_0_3, p0);
		write_cfg_reg(REG_LEVELS_4_7, p1);
		write_cfg_reg(REG_LEVELS_8_11, p2);
		write_cfg_reg(REG_LEVELS_12_15, p3);
		cfg_valid <= 1'b0;
		@(posedge clk);
		palette_settings++;
	endtask

	function automatic logic [PAL_W-1:0] random_palette_word();
		return {$urandom, $urandom};
	endfunction

	task automatic set_random_palette();
		set_palette(random_palette_word(), random_palette_word(),
			random_palette_word(), random_palette_word());
	endtask

	task automatic offer_request(func_t f, int x, int y, int lvl);
		logic signed [COORD_W-1:0] xs;
		logic signed [COORD_W-1:0] ys;
		logic [GREY_W-1:0] ls;
		xs = x[COORD_W-1:0];
		ys = y[COORD_W-1:0];
		ls = lvl[GREY_W-1:0];
		in_valid   <= 1'b1;
		func       <= f;
		x_coord    <= xs;
		y_coord    <= ys;
		grey_level <= ls;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(f, xs, ys, ls);
	endtask

	task automatic idle_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic offer_mixed_requests(int count);
		int burst_left;
		int sel;
		int x;
		int y;
		func_t f;
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				x = $urandom_range(0, 23);
				y = $urandom_range(0, 5);
			end else if (sel < 78) begin
				x = $urandom_range(0, PANEL_W - 1);
				y = $urandom_range(0, PANEL_H - 1);
			end else if (sel < 93) begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
			end else begin
				case ($urandom_range(0, 3))
					0: x = -1;
					1: x = 0;
					2: x = PANEL_W - 1;
					default: x = PANEL_W;
				endcase
				case ($urandom_range(0, 3))
					0: y = -1;
					1: y = 0;
					2: y = PANEL_H - 1;
					default: y = PANEL_H;
				endcase
			end
			sel = $urandom_range(0, 999);
			if (sel < 4 && random_fills < 6) begin
				f = FUNC_FILL;
				random_fills++;
			end else if (sel < 350) begin
				f = FUNC_PLOT;
			end else if (sel < 650) begin
				f = FUNC_MAX;
			end else begin
				f = FUNC_READ;
			end
			offer_request(f, x, y, $urandom_range(0, 15));
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 10));
			end else begin
				burst_left--;
			end
		end
	endtask

	// receiver: runs of ready/stall, plus one long hold-off to back up the input side
	initial begin : receiver
		int run_left;
		int hold_left;
		bit run_ready;
		bit hold_done;
		logic ready_next;
		run_left = 0;
		hold_left = 0;
		run_ready = 1'b1;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_colours(left_colour, right_colour, accepted);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && results_seen >= 600) begin
				hold_done = 1'b1;
				hold_left = 300;
				ready_next = 1'b0;
			end else begin
				if (run_left == 0) begin
					run_ready = ($urandom_range(0, 99) < 70);
					run_left = run_ready ? $urandom_range(1, 30) : $urandom_range(1, 6);
				end
				run_left--;
				ready_next = run_ready;
			end
			out_ready <= ready_next;
		end
	end

	initial begin
		#15_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_random_palette();

		// pixel pairs, max-blend, edges, off-screen, fill
		offer_request(FUNC_READ, 5, 3, 0);
		offer_request(FUNC_PLOT, 0, 0, 15);
		offer_request(FUNC_PLOT, 1, 0, 1);
		offer_request(FUNC_READ, 0, 0, 0);
		offer_request(FUNC_READ, 1, 0, 0);
		offer_request(FUNC_MAX, 0, 0, 3);
		offer_request(FUNC_MAX, 1, 0, 9);
		offer_request(FUNC_READ, 1, 0, 0);
		offer_request(FUNC_PLOT, PANEL_W - 1, PANEL_H - 1, 7);
		offer_request(FUNC_READ, PANEL_W - 2, PANEL_H - 1, 0);
		offer_request(FUNC_PLOT, -1, 0, 4);
		offer_request(FUNC_PLOT, PANEL_W, 5, 4);
		offer_request(FUNC_READ, 0, PANEL_H, 0);
		offer_request(FUNC_MAX, 5, -1, 15);
		offer_request(FUNC_READ, -2048, -2048, 0);
		offer_request(FUNC_PLOT, 2047, 2047, 15);
		offer_request(FUNC_PLOT, 0, PANEL_H - 1, 12);
		offer_request(FUNC_READ, 0, PANEL_H - 1, 0);
		offer_request(FUNC_FILL, 2047, -2048, 10);
		offer_request(FUNC_READ, 100, 100, 0);
		offer_request(FUNC_MAX, 100, 100, 10);
		offer_request(FUNC_MAX, 100, 100, 11);
		offer_request(FUNC_READ, 100, 100, 0);
		offer_request(FUNC_FILL, 0, 0, 0);
		offer_request(FUNC_READ, PANEL_W - 1, 0, 0);
		wait_drained();

		set_palette('0, '0, '0, '0);
		offer_mixed_requests(500);
		wait_drained();

		set_palette('1, '1, '1, '1);
		offer_mixed_requests(250);
		wait_drained();
		offer_mixed_requests(250);
		wait_drained();

		set_random_palette();
		offer_mixed_requests(500);
		wait_drained();

		set_random_palette();
		offer_mixed_requests(500);
		wait_drained();

		repeat (20) @(posedge clk);
		$display("Covered %0d requests: %0d fills, %0d pair reads, %0d off-screen,",
			sb.requests, sb.fills, sb.reads, sb.offscreen);
		$display("checked %0d results over %0d palette settings", results_seen,
			palette_settings);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
